### rtl/lcdws_pkg.sv
`default_nettype none

package lcdws_pkg;

  // request kinds
  localparam logic [2:0] ACT_INIT   = 3'd0;
  localparam logic [2:0] ACT_CMD    = 3'd1;
  localparam logic [2:0] ACT_DATA   = 3'd2;
  localparam logic [2:0] ACT_CURSOR = 3'd3;
  localparam logic [2:0] ACT_CLEAR  = 3'd4;
  localparam logic [2:0] ACT_NUMBER = 3'd5;
  localparam logic [2:0] ACT_GLYPH  = 3'd6;

  // configuration register indexes
  localparam logic [1:0] CFG_POWERUP = 2'd0;
  localparam logic [1:0] CFG_EN_HIGH = 2'd1;
  localparam logic [1:0] CFG_EN_LOW  = 2'd2;

  // hd44780 command bytes
  localparam logic [7:0] LCD_FUNC_8BIT = 8'h38;
  localparam logic [7:0] LCD_DISP_ON   = 8'h0C;
  localparam logic [7:0] LCD_CLEAR     = 8'h01;
  localparam logic [7:0] LCD_ENTRY     = 8'h06;
  localparam logic [7:0] LCD_DDRAM_R0  = 8'h80;
  localparam logic [7:0] LCD_DDRAM_R1  = 8'hC0;
  localparam logic [3:0] ASCII_ZERO_HI = 4'h3;
  localparam logic [1:0] CGRAM_HI      = 2'b01;

  localparam int unsigned NUM_BITS   = 32;
  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned PC_W       = 4;
  localparam int unsigned CNT_W      = 5;

  localparam logic [CNT_W-1:0] CNT_DABBLE = CNT_W'(NUM_BITS - 1);
  localparam logic [CNT_W-1:0] CNT_DIGITS = CNT_W'(NUM_DIGITS - 1);
  localparam logic [CNT_W-1:0] CNT_GLYPH  = CNT_W'(7);

  // routine entry points in the control store
  localparam logic [PC_W-1:0] PC_INIT   = 4'd0;
  localparam logic [PC_W-1:0] PC_CMD    = 4'd5;
  localparam logic [PC_W-1:0] PC_DATA   = 4'd6;
  localparam logic [PC_W-1:0] PC_CURSOR = 4'd7;
  localparam logic [PC_W-1:0] PC_CLEAR  = 4'd8;
  localparam logic [PC_W-1:0] PC_NUMBER = 4'd9;
  localparam logic [PC_W-1:0] PC_GLYPH  = 4'd12;

  typedef enum logic [2:0] {
    OP_IDLE_EV,
    OP_BYTE,
    OP_DABBLE,
    OP_SKIPZ,
    OP_NOP
  } op_t;

  typedef enum logic [2:0] {
    SRC_LIT,
    SRC_IN,
    SRC_CURSOR,
    SRC_DIGIT,
    SRC_CGADDR,
    SRC_GLYPH,
    SRC_SLOT
  } src_t;

  typedef struct packed {
    op_t              op;
    src_t             src;
    logic             rs;
    logic [1:0]       gap;
    logic [7:0]       lit;
    logic             rep;
    logic             skip_cur;
    logic             fin;
    logic             ld;
    logic [CNT_W-1:0] ld_val;
  } uop_t;

  typedef struct packed {
    logic load;
    logic dabble;
    logic shift;
  } bcd_ctl_t;

endpackage

`default_nettype wire

### rtl/lcdws_ucode.sv
`default_nettype none

module lcdws_ucode
  import lcdws_pkg::*;
(
  input  wire logic [PC_W-1:0] pc,
  input  wire logic [2:0]      action,
  output uop_t                 uop,
  output logic [PC_W-1:0]      entry_pc,
  output logic                 entry_ok
);

  always_comb begin
    uop = '{op: OP_NOP, src: SRC_LIT, rs: 1'b0, gap: 2'd0, lit: 8'h00, rep: 1'b0,
            skip_cur: 1'b0, fin: 1'b1, ld: 1'b0, ld_val: '0};
    unique case (pc)
      // power-up init
      4'd0: uop = '{OP_IDLE_EV, SRC_LIT, 1'b0, 2'd0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, '0};
      4'd1: uop = '{OP_BYTE, SRC_LIT, 1'b0, 2'd1, LCD_FUNC_8BIT, 1'b0, 1'b0, 1'b0, 1'b0, '0};
      4'd2: uop = '{OP_BYTE, SRC_LIT, 1'b0, 2'd1, LCD_DISP_ON, 1'b0, 1'b0, 1'b0, 1'b0, '0};
      4'd3: uop = '{OP_BYTE, SRC_LIT, 1'b0, 2'd2, LCD_CLEAR, 1'b0, 1'b0, 1'b0, 1'b0, '0};
      4'd4: uop = '{OP_BYTE, SRC_LIT, 1'b0, 2'd0, LCD_ENTRY, 1'b0, 1'b0, 1'b1, 1'b0, '0};
      // raw command, data char, cursor, clear
      4'd5: uop = '{OP_BYTE, SRC_IN, 1'b0, 2'd0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, '0};
      4'd6: uop = '{OP_BYTE, SRC_IN, 1'b1, 2'd0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, '0};
      4'd7: uop = '{OP_BYTE, SRC_CURSOR, 1'b0, 2'd0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, '0};
      4'd8: uop = '{OP_BYTE, SRC_LIT, 1'b0, 2'd0, LCD_CLEAR, 1'b0, 1'b0, 1'b1, 1'b0, '0};
      // decimal print
      4'd9: uop = '{OP_DABBLE, SRC_LIT, 1'b0, 2'd0, 8'h00, 1'b1, 1'b0, 1'b0, 1'b1,
                    CNT_DIGITS};
      4'd10: uop = '{OP_SKIPZ, SRC_LIT, 1'b0, 2'd0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, '0};
      4'd11: uop = '{OP_BYTE, SRC_DIGIT, 1'b1, 2'd0, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0, '0};
      // custom character
      4'd12: uop = '{OP_BYTE, SRC_CGADDR, 1'b0, 2'd0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1,
                     CNT_GLYPH};
      4'd13: uop = '{OP_BYTE, SRC_GLYPH, 1'b1, 2'd0, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, '0};
      4'd14: uop = '{OP_BYTE, SRC_CURSOR, 1'b0, 2'd0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, '0};
      4'd15: uop = '{OP_BYTE, SRC_SLOT, 1'b1, 2'd0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, '0};
      default: ;
    endcase
  end

  always_comb begin
    entry_ok = 1'b1;
    entry_pc = PC_INIT;
    unique case (action)
      ACT_INIT:   entry_pc = PC_INIT;
      ACT_CMD:    entry_pc = PC_CMD;
      ACT_DATA:   entry_pc = PC_DATA;
      ACT_CURSOR: entry_pc = PC_CURSOR;
      ACT_CLEAR:  entry_pc = PC_CLEAR;
      ACT_NUMBER: entry_pc = PC_NUMBER;
      ACT_GLYPH:  entry_pc = PC_GLYPH;
      default:    entry_ok = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/lcdws_bcd.sv
`default_nettype none

module lcdws_bcd
  import lcdws_pkg::*;
(
  input  wire logic                clk,
  input  wire bcd_ctl_t            ctl,
  input  wire logic [NUM_BITS-1:0] number,
  output logic [3:0]               top_digit
);

  localparam int unsigned BCD_W = 4 * NUM_DIGITS;

  logic [NUM_BITS-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0]    bcd_r, bcd_nxt;
  logic [BCD_W-1:0]    adj;

  // add-3 correction on every digit before the shift
  always_comb begin
    for (int d = 0; d < NUM_DIGITS; d++) begin
      adj[4*d +: 4] = (bcd_r[4*d +: 4] >= 4'd5) ? bcd_r[4*d +: 4] + 4'd3 : bcd_r[4*d +: 4];
    end
  end

  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    if (ctl.load) begin
      bin_nxt = number;
      bcd_nxt = '0;
    end else if (ctl.dabble) begin
      bin_nxt = {bin_r[NUM_BITS-2:0], 1'b0};
      bcd_nxt = {adj[BCD_W-2:0], bin_r[NUM_BITS-1]};
    end else if (ctl.shift) begin
      bcd_nxt = {bcd_r[BCD_W-5:0], 4'd0};
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign top_digit = bcd_r[BCD_W-1 -: 4];

endmodule

`default_nettype wire

### rtl/char_lcd_write_sequencer.sv
`default_nettype none

// channel  dir  handshake            payload
// in_      in   in_valid/in_ready    action byte_value row column number glyph_rows glyph_slot
// out_     out  out_valid/out_ready  reg_select read_write data_bus enable wait_ms last
// cfg_     in   cfg_we               cfg_index cfg_wdata
//
// a request is taken only while idle, then its routine runs step by step;
// each byte is two transactions (enable high, enable low), a skipped cursor step sends none
// a decimal print converts all 32 bits of the number to bcd, drops leading zeros
// and prints the remaining digits; a glyph sends its cgram address and 8 pattern rows
// a stalled output holds the step counter on byte steps, conversion runs on
// reset restores the register defaults and empties the output register

module char_lcd_write_sequencer
  import lcdws_pkg::*;
#(
  parameter int unsigned COLUMNS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_action,
  input  wire logic [7:0]  in_byte_value,
  input  wire logic [1:0]  in_row,
  input  wire logic [7:0]  in_column,
  input  wire logic [31:0] in_number,
  input  wire logic [63:0] in_glyph_rows,
  input  wire logic [2:0]  in_glyph_slot,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_reg_select,
  output logic             out_read_write,
  output logic [7:0]       out_data_bus,
  output logic             out_enable,
  output logic [7:0]       out_wait_ms,
  output logic             out_last,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_wdata
);

  localparam logic [7:0] COL_LIM = 8'(COLUMNS);

  // configuration
  logic [7:0] powerup_r;
  logic [3:0] en_high_r;
  logic [3:0] en_low_r;

  // sequencer state
  logic             busy_r, busy_nxt;
  logic [PC_W-1:0]  pc_r, pc_nxt;
  logic             phase_r, phase_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // captured request
  logic [7:0]  byte_r;
  logic [1:0]  row_r;
  logic [7:0]  col_r;
  logic [2:0]  slot_r;
  logic [63:0] glyph_r, glyph_nxt;

  // output register
  logic       out_valid_r;
  logic       out_rs_r;
  logic [7:0] out_data_r;
  logic       out_en_r;
  logic [7:0] out_wait_r;
  logic       out_last_r;

  uop_t            uop;
  logic [PC_W-1:0] entry_pc;
  logic            entry_ok;
  bcd_ctl_t        bcd_ctl;
  logic [3:0]      top_digit;

  logic       in_fire;
  logic       can_emit;
  logic       cur_ok;
  logic [7:0] cur_byte;
  logic [7:0] src_byte;
  logic       emit;
  logic       e_rs;
  logic [7:0] e_data;
  logic       e_en;
  logic [7:0] e_wait;
  logic       e_last;
  logic       looping;

  lcdws_ucode u_ucode (
    .pc       (pc_r),
    .action   (in_action),
    .uop      (uop),
    .entry_pc (entry_pc),
    .entry_ok (entry_ok)
  );

  lcdws_bcd u_bcd (
    .clk       (clk),
    .ctl       (bcd_ctl),
    .number    (in_number),
    .top_digit (top_digit)
  );

  assign in_ready = !busy_r;
  assign in_fire  = in_valid && in_ready;
  // output register frees up in the same cycle it is taken
  assign can_emit = !out_valid_r || out_ready;

  // cursor command, dropped when off screen
  assign cur_ok   = (row_r <= 2'd1) && (col_r < COL_LIM);
  assign cur_byte = (row_r[0] ? LCD_DDRAM_R1 : LCD_DDRAM_R0) + col_r;

  always_comb begin
    case (uop.src)
      SRC_LIT:    src_byte = uop.lit;
      SRC_IN:     src_byte = byte_r;
      SRC_CURSOR: src_byte = cur_byte;
      SRC_DIGIT:  src_byte = {ASCII_ZERO_HI, top_digit};
      SRC_CGADDR: src_byte = {CGRAM_HI, slot_r, 3'b000};
      SRC_GLYPH:  src_byte = glyph_r[7:0];
      SRC_SLOT:   src_byte = {5'd0, slot_r};
      default:    src_byte = uop.lit;
    endcase
  end

  // a repeating step stays put until its count runs out
  assign looping = uop.rep && (cnt_r != '0);

  always_comb begin
    busy_nxt  = busy_r;
    pc_nxt    = pc_r;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    glyph_nxt = glyph_r;
    bcd_ctl   = '{load: 1'b0, dabble: 1'b0, shift: 1'b0};
    emit      = 1'b0;
    e_rs      = uop.rs;
    e_data    = src_byte;
    e_en      = !phase_r;
    e_wait    = phase_r ? {4'd0, en_low_r} + {6'd0, uop.gap} : {4'd0, en_high_r};
    e_last    = 1'b0;

    if (busy_r) begin
      unique case (uop.op)
        OP_IDLE_EV: begin
          if (can_emit) begin
            emit   = 1'b1;
            e_rs   = 1'b0;
            e_data = 8'h00;
            e_en   = 1'b0;
            e_wait = powerup_r;
            e_last = uop.fin;
            pc_nxt = 4'(pc_r + 1'b1);
            busy_nxt = !uop.fin;
          end
        end
        OP_BYTE: begin
          if (uop.skip_cur && !cur_ok) begin
            pc_nxt   = 4'(pc_r + 1'b1);
            busy_nxt = !uop.fin;
          end else if (can_emit) begin
            emit = 1'b1;
            if (!phase_r) begin
              phase_nxt = 1'b1;
            end else begin
              // byte done on the enable-low event
              phase_nxt = 1'b0;
              e_last    = uop.fin && !looping;
              // next pattern row only after a pattern byte
              if (uop.src == SRC_GLYPH) glyph_nxt = {8'd0, glyph_r[63:8]};
              if (looping) begin
                cnt_nxt       = cnt_r - 1'b1;
                bcd_ctl.shift = (uop.src == SRC_DIGIT);
              end else begin
                pc_nxt   = 4'(pc_r + 1'b1);
                busy_nxt = !uop.fin;
                if (uop.ld) cnt_nxt = uop.ld_val;
              end
            end
          end
        end
        OP_DABBLE: begin
          bcd_ctl.dabble = 1'b1;
          if (looping) begin
            cnt_nxt = cnt_r - 1'b1;
          end else begin
            pc_nxt = 4'(pc_r + 1'b1);
            if (uop.ld) cnt_nxt = uop.ld_val;
          end
        end
        OP_SKIPZ: begin
          // drop leading zeros, always keep the last digit
          if (top_digit == 4'd0 && cnt_r != '0) begin
            bcd_ctl.shift = 1'b1;
            cnt_nxt       = cnt_r - 1'b1;
          end else begin
            pc_nxt = 4'(pc_r + 1'b1);
          end
        end
        default: busy_nxt = 1'b0;
      endcase
    end else if (in_fire) begin
      busy_nxt     = entry_ok;
      pc_nxt       = entry_pc;
      phase_nxt    = 1'b0;
      cnt_nxt      = CNT_DABBLE;
      glyph_nxt    = in_glyph_rows;
      bcd_ctl.load = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= PC_INIT;
      phase_r     <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      powerup_r   <= 8'd50;
      en_high_r   <= 4'd1;
      en_low_r    <= 4'd1;
    end else begin
      busy_r  <= busy_nxt;
      pc_r    <= pc_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_POWERUP: powerup_r <= cfg_wdata;
          CFG_EN_HIGH: en_high_r <= cfg_wdata[3:0];
          CFG_EN_LOW:  en_low_r  <= cfg_wdata[3:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    glyph_r <= glyph_nxt;
    if (in_fire) begin
      byte_r <= in_byte_value;
      row_r  <= in_row;
      col_r  <= in_column;
      slot_r <= in_glyph_slot;
    end
    if (emit) begin
      out_rs_r   <= e_rs;
      out_data_r <= e_data;
      out_en_r   <= e_en;
      out_wait_r <= e_wait;
      out_last_r <= e_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_reg_select = out_rs_r;
  assign out_read_write = 1'b0;
  assign out_data_bus   = out_data_r;
  assign out_enable     = out_en_r;
  assign out_wait_ms    = out_wait_r;
  assign out_last       = out_last_r;

  // unknown action is dropped without starting a routine
  a_drop_unknown: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !entry_ok |=> !busy_r)
    else $error("unknown action started a routine");

  // enable-low half of a byte only inside a byte step
  a_phase_in_byte: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> busy_r && uop.op == OP_BYTE)
    else $error("byte phase set outside a byte step");

  // conversion never produces a transaction
  a_dabble_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && uop.op == OP_DABBLE && out_valid_r |=> !(out_valid_r && !$past(out_ready))
      || $stable(out_data_bus))
    else $error("output changed during conversion");

  // digit count stays within ten digits
  a_digit_count: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && uop.op == OP_BYTE && uop.src == SRC_DIGIT |-> cnt_r <= CNT_DIGITS)
    else $error("digit counter out of range");

endmodule

`default_nettype wire
